### src/dsfr_pkg.sv
// shared types, codes and reset constants of the dle/stx frame receiver
package dsfr_pkg;

  localparam logic [7:0] SYM_DLE = 8'h10;
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;

  localparam logic [31:0] STATION_ID_RST  = 32'd123131;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd30;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned HDR_LAST     = 7;
  localparam int unsigned HDR_ID_FIRST = 4;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_END     = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  typedef enum logic {
    CFG_STATION_ID  = 1'b0,
    CFG_MAX_PAYLOAD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] length;
    logic        last;
  } res_t;

endpackage

### src/dsfr_byte_if.sv
// valid/ready channel carrying one received byte
interface dsfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### src/dsfr_res_if.sv
// valid/ready channel carrying one receiver result word
interface dsfr_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic [15:0] length;
  logic        last;

  modport source (output valid, output kind, output data, output length, output last,
                  input ready);
  modport sink (input valid, input kind, input data, input length, input last,
                output ready);
endinterface

### src/dle_stx_frame_receiver.sv
// top level of the dle/stx framed byte receiver
// throughput: one byte accepted per cycle while the result queue has room
// a result word is written into the queue at the edge that accepts the byte causing it,
// then loaded into the output register once that register is empty or its word leaves
// reset: asynchronous active low; back to hunting, queue and output emptied,
// station id and payload limit back to their defaults
module dle_stx_frame_receiver
  import dsfr_pkg::*;
#(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsfr_byte_if.sink   in_ch,
  dsfr_res_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic push_valid;
  logic push_ready;
  res_t push_data;
  logic pop_valid;
  logic pop_ready;
  res_t pop_data;

  dsfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i   (cfg_data_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  dsfr_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  dsfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_ch      (out_ch)
  );

endmodule

### src/dsfr_front.sv
// front end: accepts bytes, runs the framing state machine, pushes result words
module dsfr_front
  import dsfr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  dsfr_byte_if.sink     in_ch,
  input  logic          cfg_we_i,
  input  cfg_idx_e      cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          push_ready_i,
  output logic          push_valid_o,
  output res_t          push_data_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_FIRST,
    PH_PAYLOAD
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  prior_q, prior_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [31:0] dest_q, dest_d;
  logic [7:0]  pend_q, pend_d;
  logic [15:0] count_q, count_d;
  logic [31:0] station_q;
  logic [15:0] maxpay_q;

  logic        accept;
  logic        emit;
  res_t        res;
  logic [7:0]  b;
  logic [31:0] dest_next;
  logic [15:0] count_inc;
  logic [15:0] limit;

  assign in_ch.ready = push_ready_i;
  assign accept      = in_ch.valid & push_ready_i;
  assign b           = in_ch.rx_byte;
  assign dest_next   = {b, dest_q[31:8]};
  assign count_inc   = count_q + 16'd1;
  assign limit       = (maxpay_q == 16'd0) ? 16'd1 : maxpay_q;

  always_comb begin
    phase_d = phase_q;
    prior_d = prior_q;
    hidx_d  = hidx_q;
    dest_d  = dest_q;
    pend_d  = pend_q;
    count_d = count_q;
    emit    = 1'b0;
    res     = '{kind: KIND_PAYLOAD, data: 8'd0, length: 16'd0, last: 1'b0};
    case (phase_q)
      PH_HUNT: begin
        if (prior_q == SYM_DLE && b == SYM_STX) begin
          phase_d = PH_HEADER;
          hidx_d  = 3'd0;
          dest_d  = 32'd0;
        end
        prior_d = b;
      end
      PH_HEADER: begin
        if (hidx_q >= 3'(HDR_ID_FIRST)) begin
          dest_d = dest_next;
        end
        if (hidx_q != 3'(HDR_LAST)) begin
          hidx_d = hidx_q + 3'd1;
        end else begin
          hidx_d = 3'd0;
          if (dest_next != station_q) begin
            phase_d = PH_HUNT;
            prior_d = 8'd0;
            emit    = 1'b1;
            res     = '{kind: KIND_REJECT, data: 8'd0, length: 16'd0, last: 1'b1};
          end else begin
            phase_d = PH_FIRST;
            count_d = 16'd0;
          end
        end
      end
      PH_FIRST: begin
        pend_d  = b;
        phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        emit = 1'b1;
        if (pend_q == SYM_DLE && b == SYM_ETX) begin
          // end pair: neither byte goes out
          res     = '{kind: KIND_END, data: 8'd0, length: count_q, last: 1'b1};
          phase_d = PH_HUNT;
          prior_d = 8'd0;
        end else begin
          count_d = count_inc;
          if (count_inc >= limit) begin
            // truncated: the byte arriving now is dropped
            res     = '{kind: KIND_PAYLOAD, data: pend_q, length: count_inc, last: 1'b1};
            phase_d = PH_HUNT;
            prior_d = 8'd0;
          end else begin
            res    = '{kind: KIND_PAYLOAD, data: pend_q, length: count_inc, last: 1'b0};
            pend_d = b;
          end
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  assign push_valid_o = accept & emit;
  assign push_data_o  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      prior_q   <= 8'd0;
      hidx_q    <= 3'd0;
      dest_q    <= 32'd0;
      pend_q    <= 8'd0;
      count_q   <= 16'd0;
      station_q <= STATION_ID_RST;
      maxpay_q  <= MAX_PAYLOAD_RST;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        prior_q <= prior_d;
        hidx_q  <= hidx_d;
        dest_q  <= dest_d;
        pend_q  <= pend_d;
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_STATION_ID:  station_q <= cfg_data_i;
          CFG_MAX_PAYLOAD: maxpay_q  <= cfg_data_i[15:0];
          default:         station_q <= station_q;
        endcase
      end
    end
  end

endmodule

### src/dsfr_fifo.sv
// short result queue between the front end and the output stage
module dsfr_fifo
  import dsfr_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  res_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output res_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("result queue lost a word on push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("result queue pointers apart while empty");
`endif

endmodule

### src/dsfr_back.sv
// output stage: takes words from the queue into a held output register
module dsfr_back
  import dsfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  res_t        pop_data_i,
  dsfr_res_if.source  out_ch
);

  logic valid_q;
  res_t data_q;
  logic load;

  // refill when empty or when the held word leaves this cycle
  assign pop_ready_o = !valid_q || out_ch.ready;
  assign load        = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= pop_data_i;
    end
  end

  assign out_ch.valid  = valid_q;
  assign out_ch.kind   = data_q.kind;
  assign out_ch.data   = data_q.data;
  assign out_ch.length = data_q.length;
  assign out_ch.last   = data_q.last;

endmodule

### dv/dsfr_frame_checker.sv
// checker for the dle/stx frame receiver: follows both channels, predicts and compares result words
module dsfr_frame_checker
  import dsfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dsfr_byte_if        in_ch,
  dsfr_res_if         out_ch,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  typedef enum logic [1:0] {
    SEEK_START,
    IN_HEADER,
    HOLD_FIRST,
    IN_BODY
  } frame_phase_e;

  logic [31:0]  own_id;
  logic [15:0]  body_limit;
  frame_phase_e phase;
  logic [7:0]   prev_byte;
  logic [2:0]   hdr_idx;
  logic [31:0]  dest_id;
  logic [7:0]   held_byte;
  logic [15:0]  body_count;

  res_t        expected_words[$];
  int unsigned mismatch_total;

  function automatic res_t make_word(kind_e k, logic [7:0] d, logic [15:0] n, logic l);
    res_t w;
    w.kind   = k;
    w.data   = d;
    w.length = n;
    w.last   = l;
    return w;
  endfunction

  // hunt register is cleared so one frame's tail never starts the next
  task automatic restart_hunt();
    phase     = SEEK_START;
    prev_byte = '0;
  endtask

  task automatic track_byte(input logic [7:0] b);
    logic [15:0] cap;
    cap = (body_limit == 16'd0) ? 16'd1 : body_limit;
    case (phase)
      SEEK_START: begin
        if (prev_byte == SYM_DLE && b == SYM_STX) begin
          phase   = IN_HEADER;
          hdr_idx = '0;
          dest_id = '0;
        end
        prev_byte = b;
      end
      IN_HEADER: begin
        if (hdr_idx >= HDR_ID_FIRST) dest_id = {b, dest_id[31:8]};
        if (hdr_idx < HDR_LAST) begin
          hdr_idx = hdr_idx + 3'd1;
        end else begin
          hdr_idx = '0;
          if (dest_id != own_id) begin
            expected_words.push_back(make_word(KIND_REJECT, 8'h00, 16'd0, 1'b1));
            restart_hunt();
          end else begin
            phase      = HOLD_FIRST;
            body_count = '0;
          end
        end
      end
      HOLD_FIRST: begin
        held_byte = b;
        phase     = IN_BODY;
      end
      default: begin
        if (held_byte == SYM_DLE && b == SYM_ETX) begin
          expected_words.push_back(make_word(KIND_END, 8'h00, body_count, 1'b1));
          restart_hunt();
        end else begin
          body_count = body_count + 16'd1;
          if (body_count >= cap) begin
            // truncated: the byte arriving now is dropped
            expected_words.push_back(make_word(KIND_PAYLOAD, held_byte, body_count, 1'b1));
            restart_hunt();
          end else begin
            expected_words.push_back(make_word(KIND_PAYLOAD, held_byte, body_count, 1'b0));
            held_byte = b;
          end
        end
      end
    endcase
  endtask

  task automatic check_word();
    res_t want;
    bit   stray;
    stray = (expected_words.size() == 0);
    if (!stray) want = expected_words.pop_front();
    if (stray || out_ch.kind !== want.kind || out_ch.data !== want.data ||
        out_ch.length !== want.length || out_ch.last !== want.last) begin
      mismatch_total++;
      if (mismatch_total <= 10) begin
        if (stray)
          $display("unexpected word: kind %0d data %02h length %0d last %0d",
                   out_ch.kind, out_ch.data, out_ch.length, out_ch.last);
        else
          $display("mismatch: expected kind %0d data %02h length %0d last %0d, got kind %0d data %02h length %0d last %0d",
                   want.kind, want.data, want.length, want.last,
                   out_ch.kind, out_ch.data, out_ch.length, out_ch.last);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id     = STATION_ID_RST;
      body_limit = MAX_PAYLOAD_RST;
      phase      = SEEK_START;
      prev_byte  = '0;
      hdr_idx    = '0;
      dest_id    = '0;
      held_byte  = '0;
      body_count = '0;
      expected_words.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_STATION_ID) own_id = cfg_data_i;
        else body_limit = cfg_data_i[15:0];
      end
      if (in_ch.valid && in_ch.ready) track_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) check_word();
    end
    pending_o    <= expected_words.size();
    mismatches_o <= mismatch_total;
  end

  initial mismatch_total = 0;

endmodule

### dv/testbench.sv
// top of the frame receiver testbench: clock, reset, byte stimulus, result stalls and verdict
module testbench;
  import dsfr_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 80;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  int unsigned mismatches;
  int unsigned pending;
  int          cycle_count = 0;
  int          sent_bytes = 0;
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;

  dsfr_byte_if byte_ch ();
  dsfr_res_if  res_ch ();

  dle_stx_frame_receiver DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (byte_ch),
    .out_ch     (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  dsfr_frame_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_ch       (byte_ch),
    .out_ch      (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= 25);
        @(posedge clk);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 25) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    sent_bytes++;
  endtask

  function automatic logic [7:0] body_byte();
    if ($urandom_range(9) == 0) return SYM_DLE;
    return 8'($urandom);
  endfunction

  task automatic send_frame(input logic [31:0] dest, input int body_len, input bit closed);
    push_byte(SYM_DLE);
    push_byte(SYM_STX);
    for (int i = 0; i < 4; i++) push_byte(8'($urandom));
    for (int i = 0; i < 4; i++) push_byte(dest[8*i +: 8]);
    for (int i = 0; i < body_len; i++) push_byte(body_byte());
    if (closed) begin
      push_byte(SYM_DLE);
      push_byte(SYM_ETX);
    end
  endtask

  // drain every expected word, then wait a while with no byte offered
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] sid, input logic [15:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STATION_ID;
    cfg_data  <= sid;
    @(posedge clk);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data  <= {16'd0, limit};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] sid, input logic [15:0] limit, input int quota,
                           input bit quiet, input bit squeeze);
    int goal;
    int roll;
    int span;
    int n;
    settle();
    program_regs(sid, limit);
    calm = quiet;
    span = (limit == 16'd0) ? 1 : ((limit > 16'd32) ? 32 : int'(limit));
    goal = sent_bytes + quota;
    if (squeeze) begin
      // long frame while results are held back, so the queue fills and input stalls
      hold_request = 1'b1;
      send_frame(sid, 40, 1'b1);
    end
    while (sent_bytes < goal) begin
      roll = $urandom_range(99);
      if (roll < 65) begin
        send_frame(sid, $urandom_range(span + 3), $urandom_range(3) != 0);
      end else if (roll < 82) begin
        send_frame(sid ^ (32'd1 << $urandom_range(31)), $urandom_range(4),
                   $urandom_range(1) != 0);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          case ($urandom_range(3))
            0: push_byte(SYM_DLE);
            1: push_byte(SYM_STX);
            2: push_byte(SYM_ETX);
            default: push_byte(8'($urandom));
          endcase
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_STATION_ID;
    cfg_data        <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default settings, empty frame, stray stx after a frame, address reject
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(STATION_ID_RST, 0, 1'b1);
    push_byte(SYM_STX);
    send_frame(~STATION_ID_RST, 0, 1'b0);

    run_phase($urandom, 16'($urandom_range(2, 12)), 215, 1'b0, 1'b0);
    run_phase(32'h0000_0000, 16'd1, 215, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 16'd0, 215, 1'b0, 1'b0);
    run_phase($urandom, 16'hFFFF, 215, 1'b0, 1'b1);
    run_phase($urandom, 16'($urandom_range(3, 20)), 215, 1'b1, 1'b0);
    run_phase(STATION_ID_RST, MAX_PAYLOAD_RST, 215, 1'b0, 1'b0);

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
